// File: design/link_session_supervisor_unit_assert.svh
// Assertion macros shared by the link session supervisor RTL.
`ifndef LINK_SESSION_SUPERVISOR_UNIT_ASSERT_SVH
`define LINK_SESSION_SUPERVISOR_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define LSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/lss_pkg.sv
// Types and constants of the link session supervisor.
package lss_pkg;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned OUT_DATA_W = 16;

	typedef enum logic [2:0] {
		PH_CHECK = 3'd0,
		PH_ADDR = 3'd1,
		PH_OFFLINE = 3'd2,
		PH_LOGIN = 3'd3,
		PH_HEART = 3'd4
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		EV_TICK = 3'd0,
		EV_LOGIN_RESULT = 3'd1,
		EV_HEARTBEAT_ANSWER = 3'd2,
		EV_MESSAGE = 3'd3,
		EV_ADDRESS_REPLY = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_TICKS = 3'd0,
		CFG_HEARTBEAT_TICKS = 3'd1,
		CFG_RECONNECT_TICKS = 3'd2,
		CFG_LOGIN_TICKS = 3'd3,
		CFG_ADDRESS_WAIT_TICKS = 3'd4
	} cfg_index_t;

	localparam logic [TICK_W-1:0] CHECK_TICKS_RST = 16'd60;
	localparam logic [TICK_W-1:0] HEARTBEAT_TICKS_RST = 16'd20;
	localparam logic [TICK_W-1:0] RECONNECT_TICKS_RST = 16'd10;
	localparam logic [TICK_W-1:0] LOGIN_TICKS_RST = 16'd45;
	localparam logic [TICK_W-1:0] ADDRESS_WAIT_TICKS_RST = 16'd30;

	localparam logic [2:0] MAX_LOGIN_ATTEMPTS = 3'd3;
	localparam logic signed [7:0] BEATS_MAX = 8'sd127;
	localparam logic signed [7:0] BEATS_MIN = -8'sd128;

	typedef struct packed {
		logic [TICK_W-1:0] check_ticks;
		logic [TICK_W-1:0] heartbeat_ticks;
		logic [TICK_W-1:0] reconnect_ticks;
		logic [TICK_W-1:0] login_ticks;
		logic [TICK_W-1:0] address_wait_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t phase;
		logic [TICK_W-1:0] ticks_left;
		logic signed [7:0] unanswered_beats;
		logic [2:0] login_attempts;
		logic link_up;
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic data_valid;
		logic logged;
		logic address_error;
	} event_t;

	typedef struct packed {
		logic [2:0] phase;
		logic send_login;
		logic send_heartbeat;
		logic send_logout;
		logic request_address;
		logic check_done;
		logic link_up;
	} result_t;

endpackage

// File: design/lss_step.sv
// Next-state and pulse logic of the session supervisor for one event.
module lss_step (
	input lss_pkg::state_t state,
	input lss_pkg::event_t evt,
	input lss_pkg::cfg_t cfg,
	output lss_pkg::state_t state_next,
	output lss_pkg::result_t res
);
	import lss_pkg::*;

	logic [TICK_W-1:0] ticks_dec;
	logic expired;
	logic beats_pos;
	logic [2:0] attempts_inc;
	logic attempts_over;
	logic login_pulse;
	logic heart_pulse;
	logic logout_pulse;
	logic addr_pulse;
	logic done_pulse;

	// The countdown stops at zero; a phase acts on the tick where it reaches zero.
	assign ticks_dec = state.ticks_left - TICK_W'(state.ticks_left != '0);
	assign expired = (ticks_dec == '0);
	assign beats_pos = !state.unanswered_beats[7] && (state.unanswered_beats != '0);
	assign attempts_inc = state.login_attempts + 3'd1;
	assign attempts_over = (attempts_inc > MAX_LOGIN_ATTEMPTS);

	always_comb begin
		state_next = state;
		case (evt.kind)
			EV_TICK: begin
				state_next.ticks_left = ticks_dec;
				case (state.phase)
					PH_CHECK: begin
						if (evt.data_valid || expired) begin
							state_next.ticks_left = '0;
							state_next.phase = PH_ADDR;
						end
					end
					PH_ADDR: begin
						if (expired) begin
							state_next.ticks_left = cfg.address_wait_ticks;
						end
					end
					PH_OFFLINE: begin
						if (expired) begin
							if (attempts_over) begin
								state_next.ticks_left = '0;
								state_next.phase = PH_ADDR;
								state_next.login_attempts = '0;
							end else begin
								state_next.ticks_left = cfg.login_ticks;
								state_next.phase = PH_LOGIN;
								state_next.login_attempts = attempts_inc;
							end
						end
					end
					PH_LOGIN: begin
						if (expired) begin
							state_next.phase = PH_OFFLINE;
							state_next.ticks_left = cfg.reconnect_ticks;
						end
					end
					PH_HEART: begin
						if (expired) begin
							if (beats_pos) begin
								state_next.unanswered_beats = '0;
								state_next.phase = PH_OFFLINE;
								state_next.ticks_left = cfg.reconnect_ticks;
							end else begin
								state_next.ticks_left = cfg.heartbeat_ticks;
								if (state.unanswered_beats != BEATS_MAX) begin
									state_next.unanswered_beats = state.unanswered_beats + 8'sd1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			EV_LOGIN_RESULT: begin
				state_next.link_up = evt.logged;
				state_next.unanswered_beats = '0;
				if (evt.logged) begin
					state_next.ticks_left = cfg.heartbeat_ticks;
					state_next.phase = PH_HEART;
					state_next.login_attempts = '0;
				end else if (state.phase != PH_ADDR) begin
					state_next.ticks_left = cfg.reconnect_ticks;
					state_next.phase = PH_OFFLINE;
				end
			end
			EV_HEARTBEAT_ANSWER: begin
				if (state.unanswered_beats != BEATS_MIN) begin
					state_next.unanswered_beats = state.unanswered_beats - 8'sd1;
				end
			end
			EV_MESSAGE: begin
				state_next.ticks_left = cfg.heartbeat_ticks;
				state_next.phase = PH_HEART;
				state_next.unanswered_beats = '0;
				state_next.login_attempts = '0;
			end
			EV_ADDRESS_REPLY: begin
				if (state.phase == PH_ADDR && !evt.address_error) begin
					state_next.phase = PH_OFFLINE;
					state_next.ticks_left = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		login_pulse = 1'b0;
		heart_pulse = 1'b0;
		logout_pulse = 1'b0;
		addr_pulse = 1'b0;
		done_pulse = 1'b0;
		if (evt.kind == EV_TICK) begin
			case (state.phase)
				PH_CHECK: done_pulse = evt.data_valid || expired;
				PH_ADDR: addr_pulse = expired;
				PH_OFFLINE: login_pulse = expired && !attempts_over;
				PH_HEART: begin
					heart_pulse = expired && !beats_pos;
					logout_pulse = expired && beats_pos;
					addr_pulse = expired && beats_pos;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.phase = state_next.phase;
		res.send_login = login_pulse;
		res.send_heartbeat = heart_pulse;
		res.send_logout = logout_pulse;
		res.request_address = addr_pulse;
		res.check_done = done_pulse;
		res.link_up = state_next.link_up;
	end

endmodule

// File: design/link_session_supervisor_unit.sv
// Top level of the link session supervisor: event register, state update and result register.
// The supervisor takes one event per clock cycle unless the result channel stalls, and returns one
// result per event; each event passes the event register and then the result register.
// The session state (phase, tick countdown, unanswered-heartbeat count, login attempts and link
// status) is updated in the same cycle that an event moves from the event register into the
// result register, so back-to-back events see each other's effects in order. The tick registers
// on the configuration port are always ready; all but check_ticks are used at the next countdown reload.
`include "link_session_supervisor_unit_assert.svh"

module link_session_supervisor_unit (
	input logic clk,
	input logic arst_n,
	// Event channel. tdata: data_valid, logged, address_error, zero fill. tuser: kind.
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [lss_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input logic [lss_pkg::KIND_W-1:0] s_axis_tuser,
	// Result channel. tdata: phase[2:0], send_login, send_heartbeat, send_logout,
	// request_address, check_done, link_up, zero fill.
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [lss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration write channel.
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lss_pkg::TICK_W-1:0] cfg_data
);
	import lss_pkg::*;

	cfg_t cfg_q;
	state_t state_q;
	state_t state_next;
	event_t evt_s1;
	result_t res_next;
	result_t res_s2;
	logic valid_s1;
	logic valid_s2;
	logic advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_ticks <= CHECK_TICKS_RST;
			cfg_q.heartbeat_ticks <= HEARTBEAT_TICKS_RST;
			cfg_q.reconnect_ticks <= RECONNECT_TICKS_RST;
			cfg_q.login_ticks <= LOGIN_TICKS_RST;
			cfg_q.address_wait_ticks <= ADDRESS_WAIT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHECK_TICKS: cfg_q.check_ticks <= cfg_data;
				CFG_HEARTBEAT_TICKS: cfg_q.heartbeat_ticks <= cfg_data;
				CFG_RECONNECT_TICKS: cfg_q.reconnect_ticks <= cfg_data;
				CFG_LOGIN_TICKS: cfg_q.login_ticks <= cfg_data;
				CFG_ADDRESS_WAIT_TICKS: cfg_q.address_wait_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// An event leaves the event register when the result register is free or being drained.
	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			evt_s1.kind <= s_axis_tuser;
			evt_s1.data_valid <= s_axis_tdata[0];
			evt_s1.logged <= s_axis_tdata[1];
			evt_s1.address_error <= s_axis_tdata[2];
		end
	end

	lss_step u_step (
		.state(state_q),
		.evt(evt_s1),
		.cfg(cfg_q),
		.state_next(state_next),
		.res(res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_CHECK;
			state_q.ticks_left <= CHECK_TICKS_RST;
			state_q.unanswered_beats <= '0;
			state_q.login_attempts <= '0;
			state_q.link_up <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {
		(OUT_DATA_W - 9)'(0),
		res_s2.link_up,
		res_s2.check_done,
		res_s2.request_address,
		res_s2.send_logout,
		res_s2.send_heartbeat,
		res_s2.send_login,
		res_s2.phase
	};

	`LSS_ASSERT(a_state_holds_when_idle, !advance |=> $stable(state_q), "state changed without an event")
	`LSS_ASSERT(a_result_matches_state, advance |=> (res_s2.phase == 3'(state_q.phase)) && (res_s2.link_up == state_q.link_up), "result does not match updated state")
	`LSS_ASSERT(a_login_in_login_phase, m_axis_tvalid && res_s2.send_login |-> res_s2.phase == 3'(PH_LOGIN), "login request outside login phase")
	`LSS_ASSERT(a_logout_goes_offline, m_axis_tvalid && res_s2.send_logout |-> res_s2.request_address && res_s2.phase == 3'(PH_OFFLINE), "logout without going offline")
	`LSS_ASSERT(a_done_goes_addr, m_axis_tvalid && res_s2.check_done |-> res_s2.phase == 3'(PH_ADDR), "check done without moving to address fetch")

endmodule
